FILE: sv/smc_pkg.sv
// smc_pkg: shared types and constants of the shuttle motor controller
// used by smc_ctrl, smc_datapath and shuttle_motor_controller
package smc_pkg;

  localparam int RANGE_W  = 16;
  localparam int LEVEL_W  = 8;
  localparam int GAIN_W   = 8;
  localparam int ZONE_W   = 16;
  localparam int DIV_W    = GAIN_W + RANGE_W;
  localparam int CNT_W    = $clog2(DIV_W);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [LEVEL_W-1:0] TARGET_RST  = 8'd235;
  localparam logic [ZONE_W-1:0]  SLOW_RST    = 16'd400;
  localparam logic [ZONE_W-1:0]  TRIGGER_RST = 16'd50;
  localparam logic [ZONE_W-1:0]  EXIT_RST    = 16'd80;
  localparam logic [GAIN_W-1:0]  GAIN_RST    = 8'd40;
  localparam logic [ZONE_W-1:0]  APPR_RST    = 16'd10;
  localparam logic [LEVEL_W-1:0] STEP_RST    = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_LEVEL = 3'd0,
    CFG_SLOW_ZONE    = 3'd1,
    CFG_TRIGGER_ZONE = 3'd2,
    CFG_EXIT_ZONE    = 3'd3,
    CFG_DECEL_GAIN   = 3'd4,
    CFG_APPROACH_MIN = 3'd5,
    CFG_RAMP_STEP    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] target_level;
    logic [ZONE_W-1:0]  slow_zone;
    logic [ZONE_W-1:0]  trigger_zone;
    logic [ZONE_W-1:0]  exit_zone;
    logic [GAIN_W-1:0]  decel_gain;
    logic [ZONE_W-1:0]  approach_min;
    logic [LEVEL_W-1:0] ramp_step;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic dec_eval;
    logic dec_sel_one;
    logic div_step;
    logic div_apply;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: sv/smc_ctrl.sv
// smc_ctrl: sequencer of the shuttle motor controller
// steps through both sensor decelerations, the shared divider and the tick update
// depends on smc_pkg
module smc_ctrl import smc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_fire,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    idle
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC2,
    S_DEC1,
    S_DIV,
    S_APPLY,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic             sel_one_r, sel_one_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt   = state_r;
    sel_one_nxt = sel_one_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.dec_sel_one = sel_one_r;
    case (state_r)
      S_IDLE: begin
        cmd.load_in = in_fire;
        if (in_fire) begin
          state_nxt = S_DEC2;
        end
      end
      S_DEC2: begin
        cmd.dec_eval    = 1'b1;
        cmd.dec_sel_one = 1'b0;
        sel_one_nxt     = 1'b0;
        cnt_nxt         = '0;
        state_nxt       = sts.needs_div ? S_DIV : S_DEC1;
      end
      S_DEC1: begin
        cmd.dec_eval    = 1'b1;
        cmd.dec_sel_one = 1'b1;
        sel_one_nxt     = 1'b1;
        cnt_nxt         = '0;
        state_nxt       = sts.needs_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.div_apply = 1'b1;
        state_nxt     = sel_one_r ? S_FIN : S_DEC1;
      end
      S_FIN: begin
        cmd.finish = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      sel_one_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      sel_one_r <= sel_one_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);

endmodule

FILE: sv/smc_datapath.sv
// smc_datapath: drive state, deceleration divider, tick update and result register
// driven by smc_ctrl commands; depends on smc_pkg
module smc_datapath import smc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [RANGE_W-1:0] range_one,
  input  logic [RANGE_W-1:0] range_two,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LEVEL_W-1:0] duty_forward,
  output logic [LEVEL_W-1:0] duty_backward,
  output logic               heading_now,
  output logic               reversed
);

  logic               heading_r, heading_nxt;
  logic               armed_r, armed_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [RANGE_W-1:0] last1_r, last2_r;
  logic [RANGE_W-1:0] r1_r, r2_r;
  logic [DIV_W-1:0]   quo_r, quo_nxt;
  logic [RANGE_W-1:0] rem_r, rem_nxt;
  logic [RANGE_W-1:0] dvs_r, dvs_nxt;
  logic               out_valid_r;
  logic [LEVEL_W-1:0] duty_f_r, duty_b_r;
  logic               head_out_r, rev_out_r;

  // deceleration test for the selected sensor
  logic [RANGE_W-1:0] prev, cur, appr;
  logic               dec_hit;
  logic [DIV_W-1:0]   product;

  always_comb begin
    prev    = cmd.dec_sel_one ? last1_r : last2_r;
    cur     = cmd.dec_sel_one ? r1_r : r2_r;
    appr    = prev - cur;
    dec_hit = (ZONE_W'(cur) < cfg.slow_zone) && (prev > cur) &&
              (ZONE_W'(appr) > cfg.approach_min);
    product = DIV_W'(cfg.decel_gain) * DIV_W'(appr);
  end

  // restoring divider step
  logic [RANGE_W:0] trial;
  logic [RANGE_W:0] shifted;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    trial   = shifted - {1'b0, dvs_r};
  end

  // end of tick update
  logic               flip;
  logic [RANGE_W-1:0] ahead;
  logic [LEVEL_W-1:0] lvl_a;
  logic [LEVEL_W:0]   ramp;
  logic               armed_a;

  always_comb begin
    ahead   = heading_r ? r2_r : r1_r;
    flip    = armed_r && (ZONE_W'(ahead) < cfg.trigger_zone);
    lvl_a   = flip ? '0 : level_r;
    armed_a = armed_r & ~flip;
    ramp    = {1'b0, lvl_a};
    if (!armed_a) begin
      if (lvl_a < cfg.target_level) begin
        ramp = ramp + {1'b0, cfg.ramp_step};
      end
      if (ramp > {1'b0, cfg.target_level}) begin
        ramp = (ramp >= {1'b0, cfg.ramp_step}) ? ramp - {1'b0, cfg.ramp_step} : '0;
      end
    end
  end

  always_comb begin
    heading_nxt = heading_r;
    armed_nxt   = armed_r;
    level_nxt   = level_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    dvs_nxt     = dvs_r;
    if (cmd.dec_eval && dec_hit) begin
      if (cur == '0) begin
        level_nxt = '0;
      end else begin
        quo_nxt = product;
        rem_nxt = '0;
        dvs_nxt = cur;
      end
    end
    if (cmd.div_step) begin
      quo_nxt = {quo_r[DIV_W-2:0], ~trial[RANGE_W]};
      rem_nxt = trial[RANGE_W] ? shifted[RANGE_W-1:0] : trial[RANGE_W-1:0];
    end
    if (cmd.div_apply) begin
      level_nxt = (quo_r >= DIV_W'(level_r)) ? '0 : level_r - quo_r[LEVEL_W-1:0];
    end
    if (cmd.finish) begin
      heading_nxt = heading_r ^ flip;
      level_nxt   = ramp[LEVEL_W-1:0];
      armed_nxt   = armed_a | ((ZONE_W'(r1_r) > cfg.exit_zone) &&
                               (ZONE_W'(r2_r) > cfg.exit_zone));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r   <= 1'b1;
      armed_r     <= 1'b1;
      level_r     <= '0;
      last1_r     <= '0;
      last2_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      heading_r <= heading_nxt;
      armed_r   <= armed_nxt;
      level_r   <= level_nxt;
      if (cmd.finish) begin
        last1_r <= r1_r;
        last2_r <= r2_r;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (cmd.load_in) begin
      r1_r <= range_one;
      r2_r <= range_two;
    end
    if (cmd.finish) begin
      duty_f_r   <= heading_r ? level_r : '0;
      duty_b_r   <= heading_r ? '0 : level_r;
      head_out_r <= heading_r ^ flip;
      rev_out_r  <= flip;
    end
  end

  assign sts.needs_div = dec_hit && (cur != '0);
  assign sts.out_free  = ~out_valid_r | out_ready;
  assign out_valid     = out_valid_r;
  assign duty_forward  = duty_f_r;
  assign duty_backward = duty_b_r;
  assign heading_now   = head_out_r;
  assign reversed      = rev_out_r;

endmodule

FILE: sv/shuttle_motor_controller.sv
// Shuttle motor controller: one range tick in, one drive result out. A tick runs both
// deceleration tests and the tick update; each sensor that decelerates adds a pass
// through the shared restoring divider and an apply step. A new tick is taken once the
// previous one has been written to the result register.
// Configuration registers must be written only while no tick is in progress.
// depends on smc_pkg, smc_ctrl, smc_datapath
module shuttle_motor_controller import smc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // range_one, range_two
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // duty_forward, duty_backward, heading_now,
                                           // reversed, zero fill
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    idle;
  logic    in_fire;
  logic [LEVEL_W-1:0] duty_forward, duty_backward;
  logic    heading_now, reversed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_level <= TARGET_RST;
      cfg_r.slow_zone    <= SLOW_RST;
      cfg_r.trigger_zone <= TRIGGER_RST;
      cfg_r.exit_zone    <= EXIT_RST;
      cfg_r.decel_gain   <= GAIN_RST;
      cfg_r.approach_min <= APPR_RST;
      cfg_r.ramp_step    <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_LEVEL: cfg_r.target_level <= cfg_wdata[LEVEL_W-1:0];
        CFG_SLOW_ZONE:    cfg_r.slow_zone    <= cfg_wdata[ZONE_W-1:0];
        CFG_TRIGGER_ZONE: cfg_r.trigger_zone <= cfg_wdata[ZONE_W-1:0];
        CFG_EXIT_ZONE:    cfg_r.exit_zone    <= cfg_wdata[ZONE_W-1:0];
        CFG_DECEL_GAIN:   cfg_r.decel_gain   <= cfg_wdata[GAIN_W-1:0];
        CFG_APPROACH_MIN: cfg_r.approach_min <= cfg_wdata[ZONE_W-1:0];
        CFG_RAMP_STEP:    cfg_r.ramp_step    <= cfg_wdata[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_tready = idle;
  assign in_fire   = in_tvalid & idle;

  smc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .sts     (sts),
    .cmd     (cmd),
    .idle    (idle)
  );

  smc_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd           (cmd),
    .sts           (sts),
    .range_one     (in_tdata[RANGE_W-1:0]),
    .range_two     (in_tdata[16+RANGE_W-1:16]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .duty_forward  (duty_forward),
    .duty_backward (duty_backward),
    .heading_now   (heading_now),
    .reversed      (reversed)
  );

  assign out_tdata = {6'b0, reversed, heading_now, duty_backward, duty_forward};

endmodule
